// ----- design/ida_pkg.sv -----
`timescale 1ns / 1ps
// Package for the identifier bitmap allocator: pool geometry, word layout,
// opcode and status codes, and the mark store request type. No dependencies.
package ida_pkg;

  // Pool geometry
  localparam int unsigned FIRST_ID  = 300;
  localparam int unsigned POOL_SIZE = 4096;
  localparam int unsigned ID_LIMIT  = 65536;
  localparam int unsigned SPAN      = (FIRST_ID >= ID_LIMIT) ? 0 :
                                      (POOL_SIZE > ID_LIMIT - FIRST_ID) ?
                                      (ID_LIMIT - FIRST_ID) : POOL_SIZE;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned OFS_W  = 17;

  // Mark store layout: one word holds the marks of WORD_W identifiers
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = $clog2(WORD_W);
  localparam int unsigned NW     = (SPAN + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NW > 1) ? $clog2(NW) : 1;

  // Summary search: groups of eight word-full flags
  localparam int unsigned GRP_SZ  = 8;
  localparam int unsigned GRP_OW  = $clog2(GRP_SZ);
  localparam int unsigned NG      = (NW + GRP_SZ - 1) / GRP_SZ;
  localparam int unsigned GW      = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned SUM_W   = NG * GRP_SZ;
  localparam int unsigned WIX_W   = GW + GRP_OW;

  // Marks past the end of the pool in the last word count as used
  localparam int unsigned LAST_BITS = SPAN - (NW - 1) * WORD_W;
  localparam logic [WORD_W-1:0] PAD_MASK = (LAST_BITS == WORD_W) ? '0 :
                                           ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- design/ida_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the identifier bitmap allocator:
// request beats in, result beats out. No dependencies.
interface ida_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [15:0]        release_id;

  modport source (output valid, opcode, release_id, input ready);
  modport sink   (input valid, opcode, release_id, output ready);
endinterface

interface ida_rsp_if;
  logic               valid;
  logic               ready;
  logic [15:0]        granted_id;
  logic [1:0]         status;

  modport source (output valid, granted_id, status, input ready);
  modport sink   (input valid, granted_id, status, output ready);
endinterface

// ----- design/ida_mark_store.sv -----
`timescale 1ns / 1ps
// Used-mark store: one word of marks per address, single port, registered
// read data. Per-word valid bits make unwritten words read as all free.
// Depends on ida_pkg.
module ida_mark_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ida_pkg::mem_req_t           req_i,
  output logic [ida_pkg::WORD_W-1:0]  rdata_o
);

  logic [ida_pkg::WORD_W-1:0] mem_q [ida_pkg::NW];
  logic [ida_pkg::NW-1:0]     vld_q;
  logic [ida_pkg::WORD_W-1:0] rdata_q;
  logic                       rvld_q;

  // Array body: no reset
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- design/id_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Identifier bitmap allocator, top level: request/result channels, summary
// search, read-modify-write sequencer. Depends on ida_pkg, ida_ifs, ida_mark_store.
//
// Hands out identifiers FIRST_ID .. FIRST_ID+SPAN-1 first-fit and takes them
// back. All identifiers are free after reset; no clearing pass is needed, since
// per-word valid bits in the mark store make unwritten words read as free.
// The marks live in a single-port memory of 32-bit words; a register of
// word-full flags steers each allocate straight to the first word with a free
// mark. One request is worked on at a time. An allocate goes from acceptance
// to a registered result through summary group search, group pick and memory
// read, then encode and write back, and only then is the next request taken.
// A release goes through range check and read, then clear and write back.
// Exhaustion and out-of-range releases answer after the search or range check
// alone.
// The result register holds a beat until it is taken; a new request is still
// accepted meanwhile, and its write-back waits only for the result slot.
module id_bitmap_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  ida_req_if.sink    req_i,
  ida_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_AMOD,
    S_RCHK,
    S_RMOD
  } state_e;

  state_e state_q, state_d;

  // Request holding registers
  logic [ida_pkg::ID_W-1:0]   rid_q, rid_d;

  // Word being modified and bit for release
  logic [ida_pkg::AW-1:0]     widx_q, widx_d;
  logic [ida_pkg::BIT_W-1:0]  bit_q, bit_d;

  // Word-full summary, one flag per memory word
  logic [ida_pkg::NW-1:0]     full_q, full_d;

  // Summary group search results
  logic [ida_pkg::NG-1:0]     grp_free_q, grp_free_d;
  logic [ida_pkg::GRP_OW-1:0] grp_ofs_q [ida_pkg::NG];
  logic [ida_pkg::GRP_OW-1:0] grp_ofs_d [ida_pkg::NG];

  // Result register
  logic                       rsp_valid_q, rsp_valid_d;
  logic [ida_pkg::ID_W-1:0]   rsp_id_q, rsp_id_d;
  ida_pkg::status_e           rsp_st_q, rsp_st_d;

  ida_pkg::mem_req_t          mem_req;
  logic [ida_pkg::WORD_W-1:0] rdata;

  ida_mark_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Summary group search: lowest non-full word in each group of eight
  // ---------------------------------------------------------------------------
  logic [ida_pkg::SUM_W-1:0] full_pad;

  assign full_pad = {{(ida_pkg::SUM_W - ida_pkg::NW){1'b1}}, full_q};

  always_comb begin
    for (int g = 0; g < ida_pkg::NG; g++) begin
      grp_free_d[g] = ~&full_pad[g*ida_pkg::GRP_SZ +: ida_pkg::GRP_SZ];
      grp_ofs_d[g]  = '0;
      for (int k = ida_pkg::GRP_SZ - 1; k >= 0; k--) begin
        if (!full_pad[g*ida_pkg::GRP_SZ + k]) begin
          grp_ofs_d[g] = ida_pkg::GRP_OW'(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_free_q <= grp_free_d;
    grp_ofs_q  <= grp_ofs_d;
  end

  // Pick the first group that has room
  logic                      any_free;
  logic [ida_pkg::GW-1:0]    gsel;
  logic [ida_pkg::WIX_W-1:0] pick_wix;
  logic [ida_pkg::AW-1:0]    pick_idx;

  always_comb begin
    any_free = |grp_free_q;
    gsel     = '0;
    for (int g = ida_pkg::NG - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        gsel = ida_pkg::GW'(g);
      end
    end
  end

  assign pick_wix = {gsel, grp_ofs_q[gsel]};
  assign pick_idx = pick_wix[ida_pkg::AW-1:0];

  // ---------------------------------------------------------------------------
  // Allocate: lowest clear mark in the word read back
  // ---------------------------------------------------------------------------
  logic [ida_pkg::WORD_W-1:0] eff_word;
  logic [ida_pkg::BIT_W-1:0]  free_bit;
  logic [ida_pkg::WORD_W-1:0] set_mask;
  logic                       word_full;
  logic [ida_pkg::ID_W-1:0]   alloc_id;

  always_comb begin
    eff_word = rdata | ((widx_q == ida_pkg::AW'(ida_pkg::NW - 1)) ?
                        ida_pkg::PAD_MASK : '0);
    free_bit = '0;
    for (int b = ida_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!eff_word[b]) begin
        free_bit = ida_pkg::BIT_W'(b);
      end
    end
    set_mask  = ida_pkg::WORD_W'(1) << free_bit;
    word_full = &(eff_word | set_mask);
    alloc_id  = ida_pkg::ID_W'(ida_pkg::FIRST_ID) +
                ida_pkg::ID_W'({widx_q, free_bit});
  end

  // ---------------------------------------------------------------------------
  // Release: range check and word/bit split of the offset
  // ---------------------------------------------------------------------------
  logic [ida_pkg::OFS_W-1:0] rel_ofs;
  logic                      rel_in_range;

  assign rel_ofs      = {1'b0, rid_q} - ida_pkg::OFS_W'(ida_pkg::FIRST_ID);
  assign rel_in_range = (rid_q >= ida_pkg::ID_W'(ida_pkg::FIRST_ID)) &&
                        (rel_ofs < ida_pkg::OFS_W'(ida_pkg::SPAN));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic slot_free;

  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    rid_d       = rid_q;
    widx_d      = widx_q;
    bit_d       = bit_q;
    full_d      = full_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_id_d    = rsp_id_q;
    rsp_st_d    = rsp_st_q;
    mem_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          rid_d   = req_i.release_id;
          state_d = (ida_pkg::opcode_e'(req_i.opcode) == ida_pkg::OP_ALLOC) ?
                    S_SCAN : S_RCHK;
        end
      end
      S_SCAN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (any_free) begin
          mem_req.re   = 1'b1;
          mem_req.addr = pick_idx;
          widx_d       = pick_idx;
          state_d      = S_AMOD;
        end else if (slot_free) begin
          rsp_valid_d = 1'b1;
          rsp_id_d    = '0;
          rsp_st_d    = ida_pkg::ST_EXHAUSTED;
          state_d     = S_IDLE;
        end
      end
      S_AMOD: begin
        // Hold the read word until the result slot frees up
        if (slot_free) begin
          mem_req.we     = 1'b1;
          mem_req.addr   = widx_q;
          mem_req.wdata  = rdata | set_mask;
          full_d[widx_q] = word_full;
          rsp_valid_d    = 1'b1;
          rsp_id_d       = alloc_id;
          rsp_st_d       = ida_pkg::ST_ALLOCATED;
          state_d        = S_IDLE;
        end
      end
      S_RCHK: begin
        if (rel_in_range) begin
          mem_req.re   = 1'b1;
          mem_req.addr = rel_ofs[ida_pkg::AW+ida_pkg::BIT_W-1:ida_pkg::BIT_W];
          widx_d       = rel_ofs[ida_pkg::AW+ida_pkg::BIT_W-1:ida_pkg::BIT_W];
          bit_d        = rel_ofs[ida_pkg::BIT_W-1:0];
          state_d      = S_RMOD;
        end else if (slot_free) begin
          rsp_valid_d = 1'b1;
          rsp_id_d    = '0;
          rsp_st_d    = ida_pkg::ST_IGNORED;
          state_d     = S_IDLE;
        end
      end
      S_RMOD: begin
        if (slot_free) begin
          mem_req.we     = 1'b1;
          mem_req.addr   = widx_q;
          mem_req.wdata  = rdata & ~(ida_pkg::WORD_W'(1) << bit_q);
          full_d[widx_q] = 1'b0;
          rsp_valid_d    = 1'b1;
          rsp_id_d       = '0;
          rsp_st_d       = ida_pkg::ST_RELEASED;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      full_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_id_q    <= '0;
      rsp_st_q    <= ida_pkg::ST_ALLOCATED;
      rid_q       <= '0;
      widx_q      <= '0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      full_q      <= full_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_id_q    <= rsp_id_d;
      rsp_st_q    <= rsp_st_d;
      rid_q       <= rid_d;
      widx_q      <= widx_d;
      bit_q       <= bit_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.granted_id = rsp_id_q;
  assign rsp_o.status     = rsp_st_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Write back only from a modify state, and never together with a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> ((state_q == S_AMOD || state_q == S_RMOD) && !mem_req.re))
    else $error("mark store write outside a modify step");

  // A granted identifier lies inside the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ida_pkg::ST_ALLOCATED) |->
      (rsp_o.granted_id >= ida_pkg::ID_W'(ida_pkg::FIRST_ID) &&
       ({1'b0, rsp_o.granted_id} - ida_pkg::OFS_W'(ida_pkg::FIRST_ID)) <
         ida_pkg::OFS_W'(ida_pkg::SPAN)))
    else $error("granted identifier outside the pool");

  // Any non-grant result carries a zero identifier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ida_pkg::ST_ALLOCATED) |->
      (rsp_o.granted_id == '0))
    else $error("identifier on a result that grants nothing");

  // A modify step always follows the read it depends on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_AMOD || state_q == S_RMOD) && !$stable(state_q)) |->
      $past(mem_req.re))
    else $error("modify step entered without a word read");

endmodule
